>>> rtl/core/stm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants, types and the sine table for the sequential tone mixer.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int TONE_COUNT     = 5;
    localparam int SINE_ADDR_BITS = 8;
    localparam int LENGTH_BITS    = 16;

    localparam int SAMPLE_BITS    = 16;
    localparam int AMP_BITS       = 15;
    localparam int PHASE_BITS     = 32;
    localparam int TONE_BITS      = 3;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_REGS      = 5;
    localparam int STEP_IDX_BITS  = $clog2(STEP_REGS);

    localparam int ROM_SIZE       = 1 << SINE_ADDR_BITS;
    localparam int ROM_QUARTER    = ROM_SIZE / 4;

    localparam logic [AMP_BITS-1:0] AMP_RESET = AMP_BITS'(16384);
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(800);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AMPLITUDE   = 3'd0,
        CFG_TONE_LENGTH = 3'd1,
        CFG_STEP_1      = 3'd2,
        CFG_STEP_2      = 3'd3,
        CFG_STEP_3      = 3'd4,
        CFG_STEP_4      = 3'd5,
        CFG_STEP_5      = 3'd6
    } t_cfg_reg;

    typedef logic [STEP_REGS-1:0][PHASE_BITS-1:0] t_step_bank;
    typedef logic [ROM_SIZE-1:0][SAMPLE_BITS-1:0] t_sine_rom;

    typedef struct packed {
        logic                      play;
        logic                      done;
        logic [TONE_BITS-1:0]      tone;
        logic [SINE_ADDR_BITS-1:0] sine_addr;
    } t_seq_info;

    function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] r;
        r = (t * x) >> 30;
        r = (r * x) >> 30;
        return r;
    endfunction

    // quarter-wave sine as Q15 magnitude, taylor series in Q30
    function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input logic [31:0] q);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALF_PI_Q30 * {32'd0, q}) / ROM_QUARTER;
        term = x;
        sum  = x;
        term = sq_step(term, x) / 64'd6;   sum = sum - term;
        term = sq_step(term, x) / 64'd20;  sum = sum + term;
        term = sq_step(term, x) / 64'd42;  sum = sum - term;
        term = sq_step(term, x) / 64'd72;  sum = sum + term;
        term = sq_step(term, x) / 64'd110; sum = sum - term;
        term = sq_step(term, x) / 64'd156; sum = sum + term;
        term = sq_step(term, x) / 64'd210; sum = sum - term;
        term = sq_step(term, x) / 64'd272; sum = sum + term;
        term = sq_step(term, x) / 64'd342; sum = sum - term;
        term = sq_step(term, x) / 64'd420; sum = sum + term;
        term = sq_step(term, x) / 64'd506; sum = sum - term;
        sum = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (sum > 64'd32767) begin
            sum = 64'd32767;
        end
        return sum[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        logic [SAMPLE_BITS-1:0] v;
        for (int k = 0; k < ROM_SIZE; k++) begin
            if (k <= ROM_QUARTER) begin
                v = quarter_sine(32'(k));
            end else if (k <= 2 * ROM_QUARTER) begin
                v = quarter_sine(32'(2 * ROM_QUARTER - k));
            end else if (k <= 3 * ROM_QUARTER) begin
                v = -quarter_sine(32'(k - 2 * ROM_QUARTER));
            end else begin
                v = -quarter_sine(32'(4 * ROM_QUARTER - k));
            end
            rom[k] = v;
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

>>> rtl/core/stm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_seq
// Tone sequencer: phase accumulator, sample counter and tone index.
// ----------------------------------------------------------------------------
module stm_seq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic [stm_pkg::LENGTH_BITS-1:0]       i_tone_length,
    input  stm_pkg::t_step_bank                   i_tone_step,
    output stm_pkg::t_seq_info                    o_seq
);
    import stm_pkg::*;

    logic [PHASE_BITS-1:0]  r_phase,  n_phase;
    logic [TONE_BITS-1:0]   r_index,  n_index;
    logic [LENGTH_BITS-1:0] r_count,  n_count;
    logic                   r_finished, n_finished;
    logic                   wrap;
    logic [PHASE_BITS-1:0]  step;

    always_comb begin
        wrap       = r_count >= i_tone_length;
        n_index    = r_index;
        n_count    = r_count;
        n_phase    = r_phase;
        n_finished = r_finished;
        step       = '0;
        o_seq.play      = 1'b0;
        o_seq.sine_addr = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
        if (!r_finished) begin
            if (wrap) begin
                n_index = r_index + TONE_BITS'(1);
                n_count = '0;
            end
            if (wrap && n_index >= TONE_BITS'(TONE_COUNT)) begin
                n_finished = 1'b1;
            end else begin
                o_seq.play = 1'b1;
                if (n_index < TONE_BITS'(STEP_REGS)) begin
                    step = i_tone_step[n_index[STEP_IDX_BITS-1:0]];
                end
                n_phase = r_phase + step;
                n_count = n_count + LENGTH_BITS'(1);
            end
        end
        o_seq.done = n_finished;
        o_seq.tone = n_finished ? TONE_BITS'(TONE_COUNT) : n_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_index    <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_index    <= n_index;
            r_count    <= n_count;
            r_finished <= n_finished;
        end
    end

endmodule

>>> rtl/core/stm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_mix
// Scales a sine sample by the amplitude and adds it to audio with saturation.
// ----------------------------------------------------------------------------
module stm_mix (
    input  logic signed [stm_pkg::SAMPLE_BITS-1:0] i_audio,
    input  logic signed [stm_pkg::SAMPLE_BITS-1:0] i_sine,
    input  logic        [stm_pkg::AMP_BITS-1:0]    i_amplitude,
    input  logic                                   i_play,
    output logic signed [stm_pkg::SAMPLE_BITS-1:0] o_audio
);
    import stm_pkg::*;

    logic signed [2*SAMPLE_BITS-1:0] product;
    logic signed [SAMPLE_BITS:0]     tone;
    logic signed [SAMPLE_BITS+1:0]   sum;

    localparam logic signed [SAMPLE_BITS+1:0] SAT_HI = (SAMPLE_BITS+2)'(32767);
    localparam logic signed [SAMPLE_BITS+1:0] SAT_LO = -(SAMPLE_BITS+2)'(32768);

    always_comb begin
        // floor of the product over 2^15
        product = i_sine * $signed({1'b0, i_amplitude});
        tone    = product[2*SAMPLE_BITS-1:AMP_BITS];
        sum     = (SAMPLE_BITS+2)'(i_audio) + (SAMPLE_BITS+2)'(tone);
        if (!i_play) begin
            o_audio = i_audio;
        end else if (sum > SAT_HI) begin
            o_audio = SAT_HI[SAMPLE_BITS-1:0];
        end else if (sum < SAT_LO) begin
            o_audio = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_audio = sum[SAMPLE_BITS-1:0];
        end
    end

endmodule

>>> rtl/core/sequential_tone_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_tone_mixer_core
// Mixes a sequence of sine tones into a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle while the output is not stalled. The
// first stage advances the tone sequencer and reads the sine table, and the
// second does the amplitude multiply and saturating add into the result
// register. The user writes tone steps, length and amplitude through the
// configuration port while no transaction is in flight; it is not enforced.
module sequential_tone_mixer_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [stm_pkg::SAMPLE_BITS-1:0] i_audio_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [stm_pkg::SAMPLE_BITS-1:0] o_audio_out,
    output logic                                   o_sequence_done,
    output logic        [stm_pkg::TONE_BITS-1:0]   o_tone_number,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [stm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [stm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import stm_pkg::*;

    logic [AMP_BITS-1:0]    r_amplitude;
    logic [LENGTH_BITS-1:0] r_tone_length;
    t_step_bank             r_tone_step;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_audio;
    logic signed [SAMPLE_BITS-1:0] r_s1_sine;
    logic                          r_s1_play;
    logic                          r_s1_done;
    logic [TONE_BITS-1:0]          r_s1_tone;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_audio;
    logic                          r_out_done;
    logic [TONE_BITS-1:0]          r_out_tone;

    logic                          s1_ready;
    logic                          s2_ready;
    logic                          in_accept;
    t_seq_info                     seq;
    logic signed [SAMPLE_BITS-1:0] n_out_audio;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= AMP_RESET;
            r_tone_length <= LENGTH_RESET;
            r_tone_step   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_AMPLITUDE:   r_amplitude    <= i_cfg_data[AMP_BITS-1:0];
                CFG_TONE_LENGTH: r_tone_length  <= LENGTH_BITS'(i_cfg_data[15:0]);
                CFG_STEP_1:      r_tone_step[0] <= i_cfg_data;
                CFG_STEP_2:      r_tone_step[1] <= i_cfg_data;
                CFG_STEP_3:      r_tone_step[2] <= i_cfg_data;
                CFG_STEP_4:      r_tone_step[3] <= i_cfg_data;
                CFG_STEP_5:      r_tone_step[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_accept  = i_in_valid && s1_ready;

    stm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (in_accept),
        .i_tone_length (r_tone_length),
        .i_tone_step   (r_tone_step),
        .o_seq         (seq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_audio <= i_audio_in;
            r_s1_sine  <= SINE_ROM[seq.sine_addr];
            r_s1_play  <= seq.play;
            r_s1_done  <= seq.done;
            r_s1_tone  <= seq.tone;
        end
    end

    stm_mix u_mix (
        .i_audio     (r_s1_audio),
        .i_sine      (r_s1_sine),
        .i_amplitude (r_amplitude),
        .i_play      (r_s1_play),
        .o_audio     (n_out_audio)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_audio <= n_out_audio;
            r_out_done  <= r_s1_done;
            r_out_tone  <= r_s1_tone;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_audio_out     = r_out_audio;
    assign o_sequence_done = r_out_done;
    assign o_tone_number   = r_out_tone;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_done) |=> r_s1_done)
        else $error("sequencer left the finished state");

    a_done_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sequence_done) |-> (o_tone_number == TONE_BITS'(TONE_COUNT)))
        else $error("finished result with wrong tone number");

    a_tone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tone_number <= TONE_BITS'(TONE_COUNT)))
        else $error("tone number out of range");

    a_silent_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_done) |-> !r_s1_play)
        else $error("tone played after the sequence finished");

endmodule
